### hdl/arr_pkg.sv
// Shared types and constants of the audio rate resampler.
`default_nettype none
package arr_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int RATIO_W     = 17;
	localparam int FRAMES_W    = 12;
	localparam int CHAN_W      = 2;
	localparam int CFG_W       = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int FRAC_W      = 14;
	localparam int TARGET_W    = 4;
	localparam int SUM_W       = 21;
	localparam int RATIO_SCALE = 10000;
	localparam int MAX_RUN     = 64;
	localparam int RUN_W       = 7;

	// Serial divider, one in each lane and one in the sequencer: unsigned, one quotient bit per cycle.
	localparam int DIV_NW = 21;
	localparam int DIV_DW = 14;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE_RATIO    = 2'd0,
		REG_FRAMES_IN     = 2'd1,
		REG_FRAMES_OUT    = 2'd2,
		REG_CHANNEL_COUNT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] in_ch0;
		logic signed [SAMPLE_W-1:0] in_ch1;
	} in_frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_ch0;
		logic signed [SAMPLE_W-1:0] out_ch1;
		logic                       last_of_run;
		logic                       group_overflow;
	} out_frame_t;

	typedef enum logic [2:0] {
		LN_NOP,
		LN_DIRECT,
		LN_RAMP,
		LN_ACC,
		LN_AVG,
		LN_STEP,
		LN_CLEAR
	} lane_op_t;

	typedef struct packed {
		lane_op_t              op;
		logic                  active;
		logic [FRAMES_W-1:0]   divisor;
	} lane_cmd_t;

	typedef enum logic [1:0] {
		L_IDLE,
		L_RAMP1,
		L_RAMP2,
		L_AVG
	} lane_st_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_DISPATCH,
		T_DIVG,
		T_RAMP,
		T_DIVF,
		T_ACC,
		T_AVG,
		T_LANE,
		T_EMIT,
		T_FINISH
	} top_st_t;

endpackage
`default_nettype wire

### hdl/audio_rate_resampler.sv
// Top level of the audio rate resampler: sequencer, lanes and result register.
//
// Usage: frames enter on the frame channel (valid/ready), results leave on the
// result channel (valid/ready). The register port (wr_en, wr_index, wr_data)
// sets rate_ratio, frames_in, frames_out and channel_count; write it only
// while the block is idle.
// rate_ratio below 10000 up-samples; below 20000, frames pass through when
// frames_in equals frames_out; 20000 and up down-samples by averaging groups.
// Two channel lanes run side by side, each with its own serial divider; the
// result register merges their values into one result beat.
// A ramp frame runs a group size divide (not on the last frame of the buffer)
// and two lane divides before its first beat, then gives one beat per cycle
// while the receiver takes them, up to 64 beats. A down-sampled frame adds to
// the group sums, with an extra step when a new group starts and a lane divide
// when it closes. One frame is processed at a time.
// The frame channel opens again after the last beat of a frame is loaded,
// so a beat may still wait in the result register while a new frame enters.
// A stalled receiver holds the result register and stops the sequencer at its next beat.
// Reset clears all counters, the held prior frame and the group sums, and
// restores the register defaults (ratio 10000, 160 frames, one channel).
`default_nettype none
module audio_rate_resampler import arr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 frame_valid,
	output logic                      frame_ready,
	input  wire in_frame_t            frame,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output out_frame_t                result,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data
);

	// configuration
	logic [RATIO_W-1:0]  ratio_q;
	logic [FRAMES_W-1:0] fin_q;
	logic [FRAMES_W-1:0] fout_q;
	logic [CHAN_W-1:0]   chan_q;

	// buffer state
	logic [FRAMES_W-1:0] fpos_q;
	logic [FRAMES_W-1:0] odone_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [TARGET_W-1:0] gtgt_q;
	logic [TARGET_W-1:0] gfill_q;

	// per-frame working registers
	top_st_t                    st_q, st_d;
	logic signed [SAMPLE_W-1:0] cur0_q;
	logic signed [SAMPLE_W-1:0] cur1_q;
	logic                       last_q;
	logic [FRAMES_W-1:0]        g_q;
	logic [RUN_W-1:0]           cnt_q;
	logic                       ovf_q;
	logic                       adv_q;

	out_frame_t                 res_q;
	logic                       rvalid_q;

	lane_cmd_t                  lcmd [2];
	logic                       lbusy [2];
	logic signed [SAMPLE_W-1:0] lval [2];

	logic                       div_start;
	logic [DIV_NW-1:0]          div_dvd;
	logic [DIV_DW-1:0]          div_dvs;
	logic                       div_done;
	logic [DIV_NW-1:0]          div_quo;
	logic [DIV_DW-1:0]          div_rem;

	logic                       two_ch;
	logic                       up_mode;
	logic                       pass_mode;
	logic                       last_c;
	logic                       out_free;
	logic [FRAMES_W-1:0]        g_last;
	logic [FRAMES_W:0]          od_sum;
	logic [TARGET_W:0]          fill_next;
	logic [RATIO_W:0]           frac_sum;
	logic [TARGET_W-1:0]        tgt_c;
	logic [RATIO_W:0]           frac_rem;

	assign two_ch    = chan_q[1];
	assign up_mode   = ratio_q < RATIO_W'(RATIO_SCALE);
	assign pass_mode = !up_mode && ratio_q < RATIO_W'(2 * RATIO_SCALE);
	assign last_c    = ({1'b0, fpos_q} + 1'b1) >= {1'b0, fin_q};
	assign out_free  = !rvalid_q || result_ready;
	assign g_last    = fout_q > odone_q ? fout_q - odone_q : '0;
	assign od_sum    = {1'b0, odone_q} + {1'b0, g_q};
	assign fill_next = {1'b0, gfill_q} + 1'b1;
	assign frac_sum  = (RATIO_W+1)'(frac_q) + (RATIO_W+1)'(ratio_q);

	// group size from the accumulator: compare against each multiple of the scale
	always_comb begin
		tgt_c = '0;
		for (int k = 1; k < (1 << TARGET_W); k++) begin
			if (frac_sum >= (RATIO_W+1)'(k * RATIO_SCALE)) tgt_c = TARGET_W'(k);
		end
		frac_rem = frac_sum - (RATIO_W+1)'(tgt_c * RATIO_SCALE);
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_W'(RATIO_SCALE);
			fin_q   <= FRAMES_W'(160);
			fout_q  <= FRAMES_W'(160);
			chan_q  <= CHAN_W'(1);
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_RATE_RATIO:    ratio_q <= wr_data[RATIO_W-1:0];
				REG_FRAMES_IN:     fin_q   <= wr_data[FRAMES_W-1:0];
				REG_FRAMES_OUT:    fout_q  <= wr_data[FRAMES_W-1:0];
				REG_CHANNEL_COUNT: chan_q  <= wr_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: next state, lane commands and divider start
	always_comb begin
		st_d      = st_q;
		div_start = 1'b0;
		div_dvd   = DIV_NW'(fout_q);
		div_dvs   = DIV_DW'(fin_q);
		for (int i = 0; i < 2; i++) begin
			lcmd[i].op      = LN_NOP;
			lcmd[i].active  = (i == 0) ? 1'b1 : two_ch;
			lcmd[i].divisor = g_q;
		end
		unique case (st_q)
			T_IDLE: if (frame_valid) st_d = T_DISPATCH;
			T_DISPATCH: begin
				if (up_mode) begin
					if (fin_q <= FRAMES_W'(1)) begin
						if (fout_q == '0) begin
							st_d = T_FINISH;
						end else begin
							lcmd[0].op = LN_DIRECT;
							lcmd[1].op = LN_DIRECT;
							st_d       = T_EMIT;
						end
					end else if (last_q) begin
						st_d = T_RAMP;
					end else begin
						div_start = 1'b1;
						st_d      = T_DIVG;
					end
				end else if (pass_mode) begin
					if (fin_q == fout_q) begin
						lcmd[0].op = LN_DIRECT;
						lcmd[1].op = LN_DIRECT;
						st_d       = T_EMIT;
					end else begin
						st_d = T_FINISH;
					end
				end else if (odone_q < fout_q) begin
					if (gtgt_q == '0) begin
						st_d = T_DIVF;
					end else begin
						st_d = T_ACC;
					end
				end else begin
					st_d = T_FINISH;
				end
			end
			T_DIVG: if (div_done) st_d = T_RAMP;
			T_RAMP: begin
				lcmd[0].op = LN_RAMP;
				lcmd[1].op = LN_RAMP;
				st_d       = T_LANE;
			end
			T_DIVF: st_d = T_ACC;
			T_ACC: begin
				lcmd[0].op = LN_ACC;
				lcmd[1].op = LN_ACC;
				if (gtgt_q != '0 && fill_next >= {1'b0, gtgt_q}) st_d = T_AVG;
				else st_d = T_FINISH;
			end
			T_AVG: begin
				lcmd[0].op = LN_AVG;
				lcmd[1].op = LN_AVG;
				st_d       = T_LANE;
			end
			T_LANE: begin
				if (!lbusy[0] && !lbusy[1]) st_d = (cnt_q == '0) ? T_FINISH : T_EMIT;
			end
			T_EMIT: begin
				if (out_free) begin
					if (adv_q) begin
						lcmd[0].op = LN_STEP;
						lcmd[1].op = LN_STEP;
					end
					if (cnt_q == RUN_W'(1)) st_d = T_FINISH;
				end
			end
			T_FINISH: begin
				if (last_q) begin
					lcmd[0].op = LN_CLEAR;
					lcmd[1].op = LN_CLEAR;
				end
				st_d = T_IDLE;
			end
			default: st_d = T_IDLE;
		endcase
	end

	arr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	arr_lane u_lane0 (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lcmd[0]),
		.cur    (cur0_q),
		.busy   (lbusy[0]),
		.val    (lval[0])
	);

	arr_lane u_lane1 (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lcmd[1]),
		.cur    (cur1_q),
		.busy   (lbusy[1]),
		.val    (lval[1])
	);

	// control state and buffer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= T_IDLE;
			fpos_q   <= '0;
			odone_q  <= '0;
			frac_q   <= '0;
			gtgt_q   <= '0;
			gfill_q  <= '0;
			rvalid_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			st_q <= st_d;
			if (result_ready) rvalid_q <= 1'b0;
			unique case (st_q)
				T_DISPATCH: begin
					// one-frame buffer repeats the frame; passing emits once
					if (up_mode && fin_q <= FRAMES_W'(1)) begin
						cnt_q <= fout_q > FRAMES_W'(MAX_RUN) ? RUN_W'(MAX_RUN)
							: fout_q[RUN_W-1:0];
					end else begin
						cnt_q <= RUN_W'(1);
					end
				end
				T_RAMP: begin
					cnt_q   <= g_q > FRAMES_W'(MAX_RUN) ? RUN_W'(MAX_RUN) : g_q[RUN_W-1:0];
					odone_q <= od_sum[FRAMES_W] ? '1 : od_sum[FRAMES_W-1:0];
				end
				T_DIVF: begin
					gtgt_q <= tgt_c;
					frac_q <= frac_rem[FRAC_W-1:0];
				end
				T_ACC: begin
					if (gtgt_q != '0 && fill_next >= {1'b0, gtgt_q}) begin
						gtgt_q  <= '0;
						gfill_q <= '0;
						odone_q <= odone_q + 1'b1;
					end else begin
						gfill_q <= fill_next[TARGET_W-1:0];
					end
				end
				T_EMIT: begin
					if (out_free) begin
						rvalid_q <= 1'b1;
						cnt_q    <= cnt_q - 1'b1;
					end
				end
				T_FINISH: begin
					if (last_q) begin
						fpos_q  <= '0;
						odone_q <= '0;
						frac_q  <= '0;
						gtgt_q  <= '0;
						gfill_q <= '0;
					end else begin
						fpos_q <= fpos_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// frame payload, group size and result beat
	always_ff @(posedge clk) begin
		unique case (st_q)
			T_IDLE: begin
				if (frame_valid) begin
					cur0_q <= frame.in_ch0;
					cur1_q <= two_ch ? frame.in_ch1 : '0;
					last_q <= last_c;
				end
			end
			T_DISPATCH: begin
				ovf_q <= up_mode && fin_q <= FRAMES_W'(1) && fout_q > FRAMES_W'(MAX_RUN);
				adv_q <= 1'b0;
				if (up_mode && last_q) g_q <= g_last;
			end
			T_DIVG: if (div_done) g_q <= div_quo[FRAMES_W-1:0];
			T_RAMP: begin
				ovf_q <= g_q > FRAMES_W'(MAX_RUN);
				adv_q <= 1'b1;
			end
			T_ACC: g_q <= FRAMES_W'(gtgt_q);
			T_EMIT: begin
				if (out_free) begin
					res_q.out_ch0        <= lval[0];
					res_q.out_ch1        <= lval[1];
					res_q.last_of_run    <= cnt_q == RUN_W'(1);
					res_q.group_overflow <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign frame_ready  = st_q == T_IDLE;
	assign result_valid = rvalid_q;
	assign result       = res_q;

endmodule
`default_nettype wire

### hdl/arr_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module arr_div import arr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] dividend,
	input  wire logic [DIV_DW-1:0] divisor,
	output logic                   done,
	output logic [DIV_NW-1:0]      quotient,
	output logic [DIV_DW-1:0]      remainder
);

	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], fits};
			rem_q <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

### hdl/arr_lane.sv
// One channel lane: prior sample, group sum, ramp value and step.
`default_nettype none
module arr_lane import arr_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lane_cmd_t                  cmd,
	input  wire logic signed [SAMPLE_W-1:0] cur,
	output logic                            busy,
	output logic signed [SAMPLE_W-1:0]      val
);

	lane_st_t                    st_q, st_d;
	logic signed [SAMPLE_W-1:0]  prior_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic signed [SAMPLE_W-1:0]  val_q;
	logic        [SAMPLE_W-1:0]  step_q;
	logic        [SAMPLE_W-1:0]  q1_q;
	logic        [FRAMES_W-1:0]  g_q;
	logic                        neg_q;

	logic                        div_start;
	logic signed [SUM_W-1:0]     src;
	logic        [DIV_NW-1:0]    div_dvd;
	logic        [DIV_DW-1:0]    div_dvs;
	logic                        div_done;
	logic        [DIV_NW-1:0]    div_quo;
	logic        [DIV_DW-1:0]    div_rem;
	logic        [SAMPLE_W-1:0]  sq;

	assign sq = neg_q ? SAMPLE_W'(-div_quo[SAMPLE_W-1:0]) : div_quo[SAMPLE_W-1:0];

	always_comb begin
		st_d      = st_q;
		div_start = 1'b0;
		src       = SUM_W'(cur);
		div_dvs   = DIV_DW'(g_q);
		unique case (st_q)
			L_IDLE: begin
				div_dvs = DIV_DW'(cmd.divisor);
				if (cmd.op == LN_RAMP && cmd.active && cmd.divisor != '0) begin
					div_start = 1'b1;
					st_d      = L_RAMP1;
				end else if (cmd.op == LN_AVG) begin
					src       = sum_q;
					div_start = 1'b1;
					st_d      = L_AVG;
				end
			end
			L_RAMP1: begin
				src = SUM_W'(prior_q);
				if (div_done) begin
					div_start = 1'b1;
					st_d      = L_RAMP2;
				end
			end
			L_RAMP2: begin
				if (div_done) st_d = L_IDLE;
			end
			L_AVG: begin
				if (div_done) st_d = L_IDLE;
			end
			default: st_d = L_IDLE;
		endcase
		div_dvd = src[SUM_W-1] ? DIV_NW'(-src) : DIV_NW'(src);
	end

	arr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= L_IDLE;
			prior_q <= '0;
			sum_q   <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				L_IDLE: begin
					if (cmd.op == LN_ACC) sum_q <= sum_q + SUM_W'(cur);
					if (cmd.op == LN_CLEAR) sum_q <= '0;
					if (cmd.op == LN_RAMP && cmd.active && cmd.divisor == '0) prior_q <= cur;
				end
				L_RAMP2: if (div_done) prior_q <= cur;
				L_AVG:   if (div_done) sum_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_q <= src[SUM_W-1];
		end
		unique case (st_q)
			L_IDLE: begin
				g_q <= cmd.divisor;
				unique case (cmd.op)
					LN_DIRECT: val_q <= cur;
					LN_STEP:   val_q <= val_q + $signed(step_q);
					LN_RAMP: begin
						if (!cmd.active) begin
							val_q  <= '0;
							step_q <= '0;
						end
					end
					default: ;
				endcase
			end
			L_RAMP1: if (div_done) q1_q <= sq;
			L_RAMP2: begin
				if (div_done) begin
					step_q <= q1_q - sq;
					val_q  <= prior_q;
				end
			end
			L_AVG: if (div_done) val_q <= $signed(sq);
			default: ;
		endcase
	end

	assign busy = st_q != L_IDLE;
	assign val  = val_q;

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the audio rate resampler: random frames, configs and stalls.
`timescale 1ns / 100ps
`default_nettype none

// Predicts the result beats for every accepted frame and checks them in order.
class resample_scoreboard;
	int unsigned ratio;
	int unsigned fin;
	int unsigned fout;
	int unsigned chan_reg;
	logic [15:0] prior[2];
	int unsigned pos;
	int unsigned done;
	int unsigned acc;
	int unsigned tgt;
	int unsigned filled;
	int sum[2];
	arr_pkg::out_frame_t pending[$];
	int errors;

	function new();
		ratio    = 10000;
		fin      = 160;
		fout     = 160;
		chan_reg = 1;
		prior[0] = '0;
		prior[1] = '0;
		errors   = 0;
		clear_buffer();
	endfunction

	function void clear_buffer();
		pos    = 0;
		done   = 0;
		acc    = 0;
		tgt    = 0;
		filled = 0;
		sum[0] = 0;
		sum[1] = 0;
	endfunction

	function void set_reg(arr_pkg::cfg_reg_t idx, int unsigned value);
		case (idx)
			arr_pkg::REG_RATE_RATIO:    ratio    = value & 32'h1FFFF;
			arr_pkg::REG_FRAMES_IN:     fin      = value & 32'hFFF;
			arr_pkg::REG_FRAMES_OUT:    fout     = value & 32'hFFF;
			arr_pkg::REG_CHANNEL_COUNT: chan_reg = value & 32'h3;
		endcase
	endfunction

	function void push_beat(int a, int b, bit ovf);
		arr_pkg::out_frame_t r;
		r.out_ch0        = a[15:0];
		r.out_ch1        = b[15:0];
		r.last_of_run    = 1'b0;
		r.group_overflow = ovf;
		pending.push_back(r);
	endfunction

	// Work out the beats one frame causes and advance the buffer state.
	function void note_frame(arr_pkg::in_frame_t f);
		int nc;
		int unsigned mode;
		int cur[2];
		int unsigned g;
		int unsigned n;
		int p;
		int start;
		bit last;
		logic [15:0] val[2];
		logic [15:0] stp[2];
		arr_pkg::out_frame_t tail;
		nc    = (chan_reg >= 2) ? 2 : 1;
		mode  = ratio / 10000;
		cur[0] = f.in_ch0;
		cur[1] = (nc > 1) ? int'(f.in_ch1) : 0;
		last  = (pos + 1 >= fin);
		start = pending.size();
		if (mode == 0) begin
			if (fin <= 1) begin
				// one-frame buffer: repeat the frame, keep the prior frame
				n = (fout > 64) ? 64 : fout;
				for (int k = 0; k < n; k++) push_beat(cur[0], cur[1], fout > 64);
			end else begin
				if (last) g = (fout > done) ? fout - done : 0;
				else g = fout / fin;
				if (g != 0) begin
					n = (g > 64) ? 64 : g;
					for (int c = 0; c < 2; c++) begin
						val[c] = '0;
						stp[c] = '0;
						if (c < nc) begin
							p = $signed(prior[c]);
							val[c] = prior[c];
							stp[c] = 16'(cur[c] / int'(g) - p / int'(g));
						end
					end
					for (int j = 0; j < n; j++) begin
						push_beat(val[0], val[1], g > 64);
						val[0] = val[0] + stp[0];
						val[1] = val[1] + stp[1];
					end
				end
				done = done + g;
				if (done > 4095) done = 4095;
				for (int c = 0; c < nc; c++) prior[c] = cur[c][15:0];
			end
		end else if (mode == 1) begin
			if (fin == fout) push_beat(cur[0], cur[1], 1'b0);
		end else if (done < fout) begin
			if (tgt == 0) begin
				acc = acc + ratio;
				tgt = acc / 10000;
				acc = acc - tgt * 10000;
			end
			sum[0] += cur[0];
			sum[1] += cur[1];
			filled++;
			if (tgt != 0 && filled >= tgt) begin
				push_beat(sum[0] / int'(tgt), sum[1] / int'(tgt), 1'b0);
				done++;
				tgt    = 0;
				filled = 0;
				sum[0] = 0;
				sum[1] = 0;
			end
		end
		if (pending.size() > start) begin
			tail = pending.pop_back();
			tail.last_of_run = 1'b1;
			pending.push_back(tail);
		end
		if (last) clear_buffer();
		else pos++;
	endfunction

	function void check_result(arr_pkg::out_frame_t r);
		arr_pkg::out_frame_t e;
		if (pending.size() == 0) begin
			$error("unexpected result beat %h", r);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (r.out_ch0 !== e.out_ch0) begin
			$error("out_ch0 expected %0d actual %0d", e.out_ch0, r.out_ch0);
			errors++;
		end
		if (r.out_ch1 !== e.out_ch1) begin
			$error("out_ch1 expected %0d actual %0d", e.out_ch1, r.out_ch1);
			errors++;
		end
		if (r.last_of_run !== e.last_of_run) begin
			$error("last_of_run expected %0b actual %0b", e.last_of_run, r.last_of_run);
			errors++;
		end
		if (r.group_overflow !== e.group_overflow) begin
			$error("group_overflow expected %0b actual %0b",
				e.group_overflow, r.group_overflow);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import arr_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE      = 250;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 frame_valid = 1'b0;
	logic                 frame_ready;
	in_frame_t            frame = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	out_frame_t           result;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0]     wr_data = '0;

	resample_scoreboard sb = new();
	bit quiet = 1'b0;      // drop all idling in the closing stretch
	int frames_sent = 0;
	int stall_count = 0;
	int ready_burst = 0;

	audio_rate_resampler dut (
		.clk(clk), .arst_n(arst_n),
		.frame_valid(frame_valid), .frame_ready(frame_ready), .frame(frame),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sample both channels at the rising edge; watch for a hung block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_valid && frame_ready) sb.note_frame(frame);
			if (result_valid && result_ready) sb.check_result(result);
			if ((frame_valid && frame_ready) || (result_valid && result_ready))
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Receiver: hold ready high or low for bursts of random length.
	always @(negedge clk) begin
		if (quiet) begin
			result_ready = 1'b1;
		end else if (ready_burst > 0) begin
			ready_burst--;
		end else begin
			result_ready = ($urandom_range(0, 2) != 0);
			ready_burst = $urandom_range(1, 16);
		end
	end

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
		// let a frame that causes no beats finish in the sequencer
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned value);
		@(negedge clk);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = value[CFG_W-1:0];
		sb.set_reg(idx, value);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// Drain the block, then load a full register set.
	task automatic configure(int unsigned ratio, int unsigned fin, int unsigned fout,
		int unsigned chans);
		wait_drained();
		write_reg(REG_RATE_RATIO, ratio);
		write_reg(REG_FRAMES_IN, fin);
		write_reg(REG_FRAMES_OUT, fout);
		write_reg(REG_CHANNEL_COUNT, chans);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Present one frame beat and hold it until accepted.
	task automatic send_frame(logic [15:0] a, logic [15:0] b);
		if (!quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 16)) @(negedge clk);
		@(negedge clk);
		frame_valid = 1'b1;
		frame.in_ch0 = a;
		frame.in_ch1 = b;
		do @(posedge clk); while (!frame_ready);
		@(negedge clk);
		frame_valid = 1'b0;
		frames_sent++;
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++) send_frame(pick_sample(), pick_sample());
	endtask

	task automatic random_phase();
		int unsigned ratio;
		int unsigned fin;
		int unsigned fout;
		case ($urandom_range(0, 2))
			0: ratio = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 9999);
			1: ratio = $urandom_range(10000, 19999);
			default: ratio = ($urandom_range(0, 9) == 0) ? 131071 : $urandom_range(20000, 130000);
		endcase
		fin  = $urandom_range(0, 12);
		fout = $urandom_range(0, 80);
		if ($urandom_range(0, 2) == 0) fout = fin;
		if ($urandom_range(0, 15) == 0) fin = 4095;
		if ($urandom_range(0, 15) == 0) fout = 4095;
		configure(ratio, fin, fout, $urandom_range(0, 3));
		send_random($urandom_range(8, 24));
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: pass mode at reset defaults with extreme samples.
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'h8000, 16'h7FFF);
		configure(10000, 160, 160, 2);
		send_frame(16'h0000, 16'hFFFF);
		send_frame(16'hFFFF, 16'h0000);
		// Pass mode with mismatched buffer sizes emits nothing.
		configure(19999, 5, 6, 2);
		send_frame(16'h1234, 16'h5678);
		// One-frame buffer repeats the frame; a long repeat is cut.
		configure(5000, 1, 3, 3);
		send_frame(16'h7FFF, 16'h8000);
		configure(0, 0, 100, 2);
		send_frame(16'h8000, 16'h0001);
		// Ramp with remainder on the last frame.
		configure(0, 4, 9, 1);
		send_frame(16'h7FFF, 16'h1111);
		send_frame(16'h8000, 16'h2222);
		send_frame(16'h0100, 16'h3333);
		send_frame(16'hFF00, 16'h4444);
		// Zero group size until the remainder.
		configure(9999, 4, 2, 0);
		repeat (4) send_frame(pick_sample(), pick_sample());
		// Group beyond the cap is cut and flagged.
		configure(3000, 2, 200, 2);
		send_frame(16'h8000, 16'h7FFF);
		send_frame(16'h7FFF, 16'h8000);
		// Down mode: buffer fills early, the remaining frames are ignored.
		configure(25000, 8, 2, 2);
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'h7FFF, 16'h8000);
		repeat (6) send_frame(pick_sample(), pick_sample());
		// Large ratio with a full-size buffer.
		configure(130000, 4095, 4095, 2);
		send_random(4);

		while (frames_sent < 190) random_phase();
		quiet = 1'b1;
		while (frames_sent < 210) random_phase();

		wait_drained();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire

### audio_rate_resampler.f
hdl/arr_pkg.sv
hdl/arr_div.sv
hdl/arr_lane.sv
hdl/audio_rate_resampler.sv
sim/tb_top.sv
